>>> rtl/ps2mc_pkg.sv
`default_nettype none
package ps2mc_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COORD_BITS_MIN     = 8;
   localparam int COORD_BITS_MAX     = 16;

   localparam int BYTE_BITS      = 8;
   localparam int MOTION_BITS    = 9;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;

   // header bit positions
   localparam int HDR_LEFT_POS  = 0;
   localparam int HDR_SYNC_POS  = 3;
   localparam int HDR_XSIGN_POS = 4;
   localparam int HDR_YSIGN_POS = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic [CSR_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = CSR_DATA_BITS'(1024);
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = CSR_DATA_BITS'(768);

   localparam int CURSOR_X_RESET = 512;
   localparam int CURSOR_Y_RESET = 384;

   typedef enum logic [1:0] {
      PHASE_SYNC = 2'd0,
      PHASE_X    = 2'd1,
      PHASE_Y    = 2'd2
   } phase_type;

   typedef struct packed {
      logic signed [MOTION_BITS-1:0] dx;
      logic signed [MOTION_BITS-1:0] dy;
      logic                          left;
   } packet_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] width;
      logic [CSR_DATA_BITS-1:0] height;
   } limits_type;

endpackage
`default_nettype wire

>>> rtl/ps2mc_csr.sv
`default_nettype none
module ps2mc_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   wr_en,
   input  wire  [ps2mc_pkg::CSR_INDEX_BITS-1:0]  wr_index,
   input  wire  [ps2mc_pkg::CSR_DATA_BITS-1:0]   wr_data,
   output ps2mc_pkg::limits_type                 limits
);

   ps2mc_pkg::limits_type limits_ff, limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         unique case (wr_index)
            ps2mc_pkg::CSR_SCREEN_WIDTH:  limits_in.width  = wr_data;
            ps2mc_pkg::CSR_SCREEN_HEIGHT: limits_in.height = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.width  <= ps2mc_pkg::SCREEN_WIDTH_RESET;
         limits_ff.height <= ps2mc_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule
`default_nettype wire

>>> rtl/ps2mc_framer.sv
`default_nettype none
module ps2mc_framer (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               byte_fire,
   input  wire  [ps2mc_pkg::BYTE_BITS-1:0]   rx_byte,
   output logic                              pkt_fire,
   output ps2mc_pkg::packet_type             pkt
);

   ps2mc_pkg::phase_type phase_ff, phase_in;
   logic [ps2mc_pkg::BYTE_BITS-1:0] header_ff, header_in;
   logic [ps2mc_pkg::BYTE_BITS-1:0] x_byte_ff, x_byte_in;
   logic sync_seen;

   assign sync_seen = rx_byte[ps2mc_pkg::HDR_SYNC_POS];

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (byte_fire) begin
         unique case (phase_ff)
            ps2mc_pkg::PHASE_X: phase_in = ps2mc_pkg::PHASE_Y;
            ps2mc_pkg::PHASE_Y: phase_in = ps2mc_pkg::PHASE_SYNC;
            default:            phase_in = sync_seen ? ps2mc_pkg::PHASE_X
                                                     : ps2mc_pkg::PHASE_SYNC;
         endcase
      end
   end

   // outputs and byte capture
   always_comb begin
      header_in = header_ff;
      x_byte_in = x_byte_ff;
      pkt_fire  = 1'b0;
      if (byte_fire) begin
         unique case (phase_ff)
            ps2mc_pkg::PHASE_X: x_byte_in = rx_byte;
            ps2mc_pkg::PHASE_Y: pkt_fire  = 1'b1;
            default: begin
               if (sync_seen) header_in = rx_byte;
            end
         endcase
      end
      pkt.dx   = {header_ff[ps2mc_pkg::HDR_XSIGN_POS], x_byte_ff};
      pkt.dy   = {header_ff[ps2mc_pkg::HDR_YSIGN_POS], rx_byte};
      pkt.left = header_ff[ps2mc_pkg::HDR_LEFT_POS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ps2mc_pkg::PHASE_SYNC;
         header_ff <= '0;
         x_byte_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/ps2mc_axis.sv
`default_nettype none
module ps2mc_axis #(
   parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
   input  wire         [COORD_BITS-1:0]                cur,
   input  wire  signed [ps2mc_pkg::MOTION_BITS:0]      delta,
   input  wire         [ps2mc_pkg::CSR_DATA_BITS-1:0]  limit,
   output logic        [COORD_BITS-1:0]                next
);

   localparam int LimBits  = ps2mc_pkg::CSR_DATA_BITS;
   localparam int SumBits  = ((COORD_BITS > LimBits) ? COORD_BITS : LimBits) + 2;
   localparam int CoordMax = (1 << COORD_BITS) - 1;

   logic signed [SumBits-1:0] sum;
   logic signed [SumBits-1:0] lim_ext;
   logic signed [SumBits-1:0] top;
   logic        [LimBits-1:0] lim_m1;

   assign sum     = $signed({{(SumBits-COORD_BITS){1'b0}}, cur}) + SumBits'(delta);
   // a zero limit pins the coordinate at 0
   assign lim_m1  = (limit == '0) ? '0 : limit - LimBits'(1);
   assign lim_ext = $signed({{(SumBits-LimBits){1'b0}}, lim_m1});
   assign top     = (lim_ext > SumBits'(CoordMax)) ? SumBits'(CoordMax) : lim_ext;

   always_comb begin
      priority if (sum < 0) next = '0;
      else if (sum > top)   next = top[COORD_BITS-1:0];
      else                  next = sum[COORD_BITS-1:0];
   end

endmodule
`default_nettype wire

>>> rtl/ps2_mouse_packet_cursor_top.sv
// PS/2 three-byte mouse packet decoder with clamped cursor.
// Throughput: one byte accepted per cycle; req_stall rises only while a
// decoded packet waits behind a result that rsp_stall holds.
// Path: the packet's third byte is taken into the packet register, then
// into the cursor/result register, which drives the result outputs.
// Reset: synchronous; phase 0, cursor 512/384 (saturated), limits 1024/768.
`default_nettype none
module ps2_mouse_packet_cursor_top #(
   parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [ps2mc_pkg::BYTE_BITS-1:0]       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [COORD_BITS-1:0]                 rsp_cursor_x,
   output logic [COORD_BITS-1:0]                 rsp_cursor_y,
   output logic                                  rsp_left_button,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [ps2mc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [ps2mc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CoordMax = (1 << COORD_BITS) - 1;
   localparam int XRst = (ps2mc_pkg::CURSOR_X_RESET > CoordMax) ? CoordMax
                                                                : ps2mc_pkg::CURSOR_X_RESET;
   localparam int YRst = (ps2mc_pkg::CURSOR_Y_RESET > CoordMax) ? CoordMax
                                                                : ps2mc_pkg::CURSOR_Y_RESET;
   localparam int DeltaBits = ps2mc_pkg::MOTION_BITS + 1;

   ps2mc_pkg::limits_type  limits;
   ps2mc_pkg::packet_type  pkt_new;
   ps2mc_pkg::packet_type  pkt_ff, pkt_in;
   logic                   pkt_valid_ff, pkt_valid_in;
   logic                   pkt_fire;
   logic                   req_fire;
   logic                   advance;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]  cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]  cursor_y_ff, cursor_y_in;
   logic                   left_ff, left_in;
   logic [COORD_BITS-1:0]  x_next, y_next;
   logic signed [DeltaBits-1:0] dx_ext, dy_neg;

   assign csr_ready = 1'b1;

   ps2mc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .limits   (limits)
   );

   assign advance   = pkt_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pkt_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   ps2mc_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (req_fire),
      .rx_byte   (req_rx_byte),
      .pkt_fire  (pkt_fire),
      .pkt       (pkt_new)
   );

   always_comb begin
      pkt_in       = pkt_fire ? pkt_new : pkt_ff;
      pkt_valid_in = pkt_fire || (pkt_valid_ff && !advance);
   end

   assign dx_ext = DeltaBits'(pkt_ff.dx);
   // screen y grows downward
   assign dy_neg = -DeltaBits'(pkt_ff.dy);

   ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .cur   (cursor_x_ff),
      .delta (dx_ext),
      .limit (limits.width),
      .next  (x_next)
   );

   ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .cur   (cursor_y_ff),
      .delta (dy_neg),
      .limit (limits.height),
      .next  (y_next)
   );

   // cursor registers double as the result payload
   always_comb begin
      cursor_x_in  = advance ? x_next : cursor_x_ff;
      cursor_y_in  = advance ? y_next : cursor_y_ff;
      left_in      = advance ? pkt_ff.left : left_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_x_ff  <= COORD_BITS'(XRst);
         cursor_y_ff  <= COORD_BITS'(YRst);
         left_ff      <= 1'b0;
      end else begin
         pkt_valid_ff <= pkt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_x    = cursor_x_ff;
   assign rsp_cursor_y    = cursor_y_ff;
   assign rsp_left_button = left_ff;

endmodule
`default_nettype wire

>>> rtl/ps2mc_checker.sv
`default_nettype none
module ps2mc_checker #(
   parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_valid,
   input wire                                   req_stall,
   input wire                                   rsp_valid,
   input wire                                   rsp_stall,
   input wire  [COORD_BITS-1:0]                 rsp_cursor_x,
   input wire  [COORD_BITS-1:0]                 rsp_cursor_y,
   input wire                                   rsp_left_button
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cursor_x) && $stable(rsp_cursor_y)
                                 && $stable(rsp_left_button))
      else $error("stalled result changed");

   // a new result always comes from a taken request, via the packet register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a completing request");

   // back-pressure only comes from a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no pending result");

endmodule

bind ps2_mouse_packet_cursor_top ps2mc_checker #(.COORD_BITS(COORD_BITS)) u_ps2mc_checker (.*);
`default_nettype wire
